>>> rtl/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg: shared types and constants of the chinese remainder solver
// Holds the sequencer states, status codes and the divider handshake structs.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int unsigned MAX_CONGRUENCES_DEF = 8;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned MOD_W    = 8;
  localparam int unsigned RES_IN_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned T_W      = 10;  // signed Euclid coefficient, |t| <= modulus

  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_COPRIME = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW    = 2'd2;

  // Divider runs one quotient bit per cycle; short operands skip the upper bits.
  localparam int unsigned DIV_CNT_W       = 7;
  localparam logic [DIV_CNT_W-1:0] DIV_BITS_WIDE   = 7'd64;
  localparam logic [DIV_CNT_W-1:0] DIV_BITS_NARROW = 7'd16;

  typedef struct packed {
    logic              start;
    logic              narrow;
    logic [WORD_W-1:0] dividend;
    logic [MOD_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
    logic [MOD_W-1:0]  remainder;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RED,
    S_CHECK,
    S_PAIR,
    S_PAIR_A,
    S_PAIR_B,
    S_GCD,
    S_GCD_W,
    S_PROD,
    S_TERM,
    S_COF_W,
    S_CMOD,
    S_CMOD_W,
    S_EUC,
    S_EUC_W,
    S_INV,
    S_KMUL,
    S_K_W,
    S_TMUL,
    S_ADD,
    S_OUT
  } state_t;

endpackage

>>> rtl/crs_div.sv
// ----------------------------------------------------------------------------
// crs_div: shared restoring divider
// Divides a 64-bit value by an 8-bit divisor, one quotient bit per cycle.
// A narrow request treats the dividend as 16 bits.
// ----------------------------------------------------------------------------
module crs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  crs_pkg::div_req_t req,
  output crs_pkg::div_rsp_t rsp
);

  logic [crs_pkg::WORD_W-1:0]    dvd_r, dvd_nxt;
  logic [crs_pkg::WORD_W-1:0]    quo_r, quo_nxt;
  logic [crs_pkg::MOD_W-1:0]     rem_r, rem_nxt;
  logic [crs_pkg::MOD_W-1:0]     dsr_r, dsr_nxt;
  logic [crs_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;

  logic [crs_pkg::MOD_W:0] rem_sh;
  logic [crs_pkg::MOD_W:0] rem_sub;
  logic                    ge;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[crs_pkg::WORD_W-1]};
    ge      = (rem_sh >= {1'b0, dsr_r});
    rem_sub = rem_sh - {1'b0, dsr_r};

    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (req.start) begin
      // left-align short operands so the top bit always feeds the remainder
      dvd_nxt  = req.narrow ? {req.dividend[crs_pkg::RES_IN_W-1:0],
                               {(crs_pkg::WORD_W-crs_pkg::RES_IN_W){1'b0}}}
                            : req.dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = req.narrow ? crs_pkg::DIV_BITS_NARROW : crs_pkg::DIV_BITS_WIDE;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[crs_pkg::WORD_W-2:0], 1'b0};
      quo_nxt = {quo_r[crs_pkg::WORD_W-2:0], ge};
      rem_nxt = ge ? rem_sub[crs_pkg::MOD_W-1:0] : rem_sh[crs_pkg::MOD_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == crs_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

>>> rtl/chinese_remainder_solver.sv
// ----------------------------------------------------------------------------
// chinese_remainder_solver: congruence system solver
// Collects congruences and returns the smallest x meeting all of them.
// ----------------------------------------------------------------------------
// Each request carries one congruence x = residue (mod modulus). The residue
// of a request is reduced by a 16-bit narrow pass of the shared bit-serial
// divider. The request marked last starts the solve, during which in_stall
// stays high: every pair of moduli goes through Euclid's algorithm, M is
// formed one modulus a cycle, and each congruence with a modulus above 1 then
// costs two wide divisions, for M/m and for (M/m) mod m, an extended Euclid
// inverse and a narrow reduction. The solve time is set by the one shared
// divider. The result waits in an output register, and the next set may be
// loaded while it is held.
module chinese_remainder_solver #(
  parameter int unsigned MAX_CONGRUENCES = crs_pkg::MAX_CONGRUENCES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [crs_pkg::RES_IN_W-1:0]  in_residue,
  input  logic [crs_pkg::MOD_W-1:0]     in_modulus,
  input  logic                          in_last_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [crs_pkg::WORD_W-1:0]    out_solution,
  output logic [crs_pkg::WORD_W-1:0]    out_product,
  output logic [crs_pkg::STATUS_W-1:0]  out_status
);

  localparam int unsigned IDX_W = (MAX_CONGRUENCES > 1) ? $clog2(MAX_CONGRUENCES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_CONGRUENCES + 3);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CONGRUENCES);

  localparam int unsigned W  = crs_pkg::WORD_W;
  localparam int unsigned MW = crs_pkg::MOD_W;
  localparam int unsigned TW = crs_pkg::T_W;

  logic [MW-1:0] mod_mem [MAX_CONGRUENCES];
  logic [MW-1:0] res_mem [MAX_CONGRUENCES];

  crs_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             last_r, last_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [MW-1:0]    ga_r, ga_nxt;
  logic [MW-1:0]    gb_r, gb_nxt;
  logic [MW-1:0]    mi_r, mi_nxt;
  logic [MW-1:0]    ri_r, ri_nxt;
  logic [W-1:0]     prod_r, prod_nxt;
  logic [W-1:0]     sol_r, sol_nxt;
  logic [W-1:0]     cof_r, cof_nxt;
  logic [W-1:0]     term_r, term_nxt;
  logic [MW-1:0]    r0_r, r0_nxt;
  logic [MW-1:0]    r1_r, r1_nxt;
  logic signed [TW-1:0] t0_r, t0_nxt;
  logic signed [TW-1:0] t1_r, t1_nxt;
  logic [MW-1:0]    inv_r, inv_nxt;
  logic [MW-1:0]    k_r, k_nxt;
  logic [crs_pkg::STATUS_W-1:0] status_r, status_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [W-1:0]                 out_sol_r, out_sol_nxt;
  logic [W-1:0]                 out_prod_r, out_prod_nxt;
  logic [crs_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  crs_pkg::div_req_t div_req;
  crs_pkg::div_rsp_t div_rsp;

  logic          in_acc;
  logic [MW-1:0] in_mod_fix;
  logic          mod_we, res_we;
  logic [MW-1:0] m_at_i, r_at_i, m_at_j;
  logic          out_free;
  logic signed [2*TW-1:0] qt;
  logic signed [TW-1:0]   t_fix;
  logic [2*MW-1:0]        kp;
  logic [W-1:0]           gap;

  crs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall   = (state_r != crs_pkg::S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign in_mod_fix = (in_modulus == '0) ? MW'(1) : in_modulus;
  assign m_at_i     = mod_mem[i_r[IDX_W-1:0]];
  assign r_at_i     = res_mem[i_r[IDX_W-1:0]];
  assign m_at_j     = mod_mem[j_r[IDX_W-1:0]];
  assign out_free   = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      crs_pkg::S_IDLE: begin
        if (in_acc) begin
          if (cnt_r < MAX_CNT) state_nxt = crs_pkg::S_RED;
          else if (in_last_item) state_nxt = crs_pkg::S_CHECK;
        end
      end
      crs_pkg::S_RED: begin
        if (div_rsp.done) state_nxt = last_r ? crs_pkg::S_CHECK : crs_pkg::S_IDLE;
      end
      crs_pkg::S_CHECK: state_nxt = ovf_r ? crs_pkg::S_OUT : crs_pkg::S_PAIR;
      crs_pkg::S_PAIR: begin
        if (i_r >= cnt_r) state_nxt = crs_pkg::S_PROD;
        else if (j_r < cnt_r) state_nxt = crs_pkg::S_PAIR_A;
      end
      crs_pkg::S_PAIR_A: state_nxt = crs_pkg::S_PAIR_B;
      crs_pkg::S_PAIR_B: state_nxt = crs_pkg::S_GCD;
      crs_pkg::S_GCD: begin
        if (gb_r != '0) state_nxt = crs_pkg::S_GCD_W;
        else if (ga_r != MW'(1)) state_nxt = crs_pkg::S_OUT;
        else state_nxt = crs_pkg::S_PAIR;
      end
      crs_pkg::S_GCD_W: if (div_rsp.done) state_nxt = crs_pkg::S_GCD;
      crs_pkg::S_PROD: if (i_r >= cnt_r) state_nxt = crs_pkg::S_TERM;
      crs_pkg::S_TERM: state_nxt = (i_r >= cnt_r) ? crs_pkg::S_OUT : crs_pkg::S_COF_W;
      crs_pkg::S_COF_W: begin
        if (div_rsp.done) state_nxt = (mi_r == MW'(1)) ? crs_pkg::S_TMUL : crs_pkg::S_CMOD;
      end
      crs_pkg::S_CMOD: state_nxt = crs_pkg::S_CMOD_W;
      crs_pkg::S_CMOD_W: if (div_rsp.done) state_nxt = crs_pkg::S_EUC;
      crs_pkg::S_EUC: state_nxt = (r1_r == '0) ? crs_pkg::S_INV : crs_pkg::S_EUC_W;
      crs_pkg::S_EUC_W: if (div_rsp.done) state_nxt = crs_pkg::S_EUC;
      crs_pkg::S_INV: state_nxt = crs_pkg::S_KMUL;
      crs_pkg::S_KMUL: state_nxt = crs_pkg::S_K_W;
      crs_pkg::S_K_W: if (div_rsp.done) state_nxt = crs_pkg::S_TMUL;
      crs_pkg::S_TMUL: state_nxt = crs_pkg::S_ADD;
      crs_pkg::S_ADD: state_nxt = crs_pkg::S_TERM;
      crs_pkg::S_OUT: if (out_free) state_nxt = crs_pkg::S_IDLE;
      default: state_nxt = crs_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    last_nxt   = last_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    ga_nxt     = ga_r;
    gb_nxt     = gb_r;
    mi_nxt     = mi_r;
    ri_nxt     = ri_r;
    prod_nxt   = prod_r;
    sol_nxt    = sol_r;
    cof_nxt    = cof_r;
    term_nxt   = term_r;
    r0_nxt     = r0_r;
    r1_nxt     = r1_r;
    t0_nxt     = t0_r;
    t1_nxt     = t1_r;
    inv_nxt    = inv_r;
    k_nxt      = k_r;
    status_nxt = status_r;
    mod_we     = 1'b0;
    res_we     = 1'b0;
    div_req    = '0;

    out_valid_nxt  = out_valid_r && out_stall;
    out_sol_nxt    = out_sol_r;
    out_prod_nxt   = out_prod_r;
    out_status_nxt = out_status_r;

    qt    = $signed({{(2*TW-MW){1'b0}}, div_rsp.quotient[MW-1:0]}) * $signed({{TW{t1_r[TW-1]}}, t1_r});
    t_fix = t0_r[TW-1] ? (t0_r + $signed({{(TW-MW){1'b0}}, mi_r})) : t0_r;
    if (t_fix >= $signed({{(TW-MW){1'b0}}, mi_r}))
      t_fix = t_fix - $signed({{(TW-MW){1'b0}}, mi_r});
    kp  = ri_r * inv_r;
    gap = prod_r - sol_r;

    case (state_r)
      crs_pkg::S_IDLE: begin
        if (in_acc) begin
          last_nxt = in_last_item;
          if (cnt_r < MAX_CNT) begin
            mod_we          = 1'b1;
            div_req.start    = 1'b1;
            div_req.narrow   = 1'b1;
            div_req.dividend = {{(W-crs_pkg::RES_IN_W){1'b0}}, in_residue};
            div_req.divisor  = in_mod_fix;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      crs_pkg::S_RED: begin
        if (div_rsp.done) begin
          res_we  = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      crs_pkg::S_CHECK: begin
        i_nxt   = '0;
        j_nxt   = CNT_W'(1);
        sol_nxt = '0;
        prod_nxt = '0;
        status_nxt = ovf_r ? crs_pkg::STATUS_OVERFLOW : crs_pkg::STATUS_OK;
      end
      crs_pkg::S_PAIR: begin
        if (i_r >= cnt_r) begin
          i_nxt    = '0;
          prod_nxt = W'(1);
        end else if (j_r >= cnt_r) begin
          i_nxt = i_r + 1'b1;
          j_nxt = i_r + CNT_W'(2);
        end
      end
      crs_pkg::S_PAIR_A: ga_nxt = m_at_i;
      crs_pkg::S_PAIR_B: gb_nxt = m_at_j;
      crs_pkg::S_GCD: begin
        if (gb_r != '0) begin
          div_req.start    = 1'b1;
          div_req.narrow   = 1'b1;
          div_req.dividend = {{(W-MW){1'b0}}, ga_r};
          div_req.divisor  = gb_r;
        end else if (ga_r != MW'(1)) begin
          status_nxt = crs_pkg::STATUS_NOT_COPRIME;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      crs_pkg::S_GCD_W: begin
        if (div_rsp.done) begin
          ga_nxt = gb_r;
          gb_nxt = div_rsp.remainder;
        end
      end
      crs_pkg::S_PROD: begin
        if (i_r >= cnt_r) begin
          i_nxt   = '0;
          sol_nxt = '0;
        end else begin
          prod_nxt = prod_r * {{(W-MW){1'b0}}, m_at_i};
          i_nxt    = i_r + 1'b1;
        end
      end
      crs_pkg::S_TERM: begin
        if (i_r < cnt_r) begin
          mi_nxt           = m_at_i;
          ri_nxt           = r_at_i;
          div_req.start    = 1'b1;
          div_req.narrow   = 1'b0;
          div_req.dividend = prod_r;
          div_req.divisor  = m_at_i;
        end
      end
      crs_pkg::S_COF_W: begin
        if (div_rsp.done) begin
          cof_nxt = div_rsp.quotient;
          k_nxt   = '0;
        end
      end
      crs_pkg::S_CMOD: begin
        // reduce the cofactor by its own modulus before the inverse
        div_req.start    = 1'b1;
        div_req.narrow   = 1'b0;
        div_req.dividend = cof_r;
        div_req.divisor  = mi_r;
      end
      crs_pkg::S_CMOD_W: begin
        if (div_rsp.done) begin
          r0_nxt  = mi_r;
          r1_nxt  = div_rsp.remainder;
          t0_nxt  = '0;
          t1_nxt  = TW'(1);
        end
      end
      crs_pkg::S_EUC: begin
        if (r1_r != '0) begin
          div_req.start    = 1'b1;
          div_req.narrow   = 1'b1;
          div_req.dividend = {{(W-MW){1'b0}}, r0_r};
          div_req.divisor  = r1_r;
        end
      end
      crs_pkg::S_EUC_W: begin
        if (div_rsp.done) begin
          r0_nxt = r1_r;
          r1_nxt = div_rsp.remainder;
          t0_nxt = t1_r;
          t1_nxt = t0_r - qt[TW-1:0];
        end
      end
      crs_pkg::S_INV: inv_nxt = t_fix[MW-1:0];
      crs_pkg::S_KMUL: begin
        div_req.start    = 1'b1;
        div_req.narrow   = 1'b1;
        div_req.dividend = {{(W-2*MW){1'b0}}, kp};
        div_req.divisor  = mi_r;
      end
      crs_pkg::S_K_W: if (div_rsp.done) k_nxt = div_rsp.remainder;
      crs_pkg::S_TMUL: term_nxt = cof_r * {{(W-MW){1'b0}}, k_r};
      crs_pkg::S_ADD: begin
        // wrap the running sum back below M
        sol_nxt = (term_r >= gap) ? (sol_r + term_r - prod_r) : (sol_r + term_r);
        i_nxt   = i_r + 1'b1;
      end
      crs_pkg::S_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sol_nxt    = (status_r == crs_pkg::STATUS_OK) ? sol_r : '0;
          out_prod_nxt   = (status_r == crs_pkg::STATUS_OK) ? prod_r : '0;
          out_status_nxt = status_r;
          cnt_nxt        = '0;
          ovf_nxt        = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mod_we) mod_mem[cnt_r[IDX_W-1:0]] <= in_mod_fix;
    if (res_we) res_mem[cnt_r[IDX_W-1:0]] <= div_rsp.remainder;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crs_pkg::S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_r       <= last_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    ga_r         <= ga_nxt;
    gb_r         <= gb_nxt;
    mi_r         <= mi_nxt;
    ri_r         <= ri_nxt;
    prod_r       <= prod_nxt;
    sol_r        <= sol_nxt;
    cof_r        <= cof_nxt;
    term_r       <= term_nxt;
    r0_r         <= r0_nxt;
    r1_r         <= r1_nxt;
    t0_r         <= t0_nxt;
    t1_r         <= t1_nxt;
    inv_r        <= inv_nxt;
    k_r          <= k_nxt;
    status_r     <= status_nxt;
    out_sol_r    <= out_sol_nxt;
    out_prod_r   <= out_prod_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_solution = out_sol_r;
  assign out_product  = out_prod_r;
  assign out_status   = out_status_r;

endmodule
